@@ hdl/lfr_pkg.sv @@
// lfr_pkg: shared types and constants for the LRU frame replacer.
// No dependencies; used by every module of the block except lfr_ram.
`timescale 1ns / 1ps

package lfr_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned FrameW = 6;
  localparam int unsigned CountW = 7;

  // Request kinds; the fourth code is a no-op
  typedef enum logic [KindW-1:0] {
    KindEvict = 2'd0,
    KindPin   = 2'd1,
    KindUnpin = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  typedef struct packed {
    logic load;    // request transaction taken this cycle
    logic commit;  // apply update and load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_pending;  // result register holds an untaken transaction
  } dp_status_t;

endpackage

@@ hdl/lfr_if.sv @@
// lfr_req_if / lfr_rsp_if: valid/ready channels for requests and results.
// Depends on lfr_pkg for field widths.
`timescale 1ns / 1ps

interface lfr_req_if;
  logic                         valid;
  logic                         ready;
  logic [lfr_pkg::KindW-1:0]    kind;
  logic [lfr_pkg::FrameW-1:0]   frame_index;

  modport source (output valid, output kind, output frame_index, input ready);
  modport sink   (input valid, input kind, input frame_index, output ready);
endinterface

interface lfr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         done_res;
  logic [lfr_pkg::FrameW-1:0]   victim_frame;
  logic [lfr_pkg::CountW-1:0]   evictable_count;

  modport source (output valid, output done_res, output victim_frame,
                  output evictable_count, input ready);
  modport sink   (input valid, input done_res, input victim_frame,
                  input evictable_count, output ready);
endinterface

@@ hdl/lfr_ram.sv @@
// lfr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lfr_ctrl.sv @@
// lfr_ctrl: request sequencer (idle / execute) for the LRU frame replacer.
// Depends on lfr_pkg.
`timescale 1ns / 1ps

module lfr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  rsp_ready_i,
  input  lfr_pkg::dp_status_t   status_i,
  output logic                  req_ready_o,
  output lfr_pkg::ctrl_cmd_t    cmd_o
);

  lfr_pkg::state_e state_q, state_d;
  logic            slot_free;

  assign slot_free    = !status_i.rsp_pending || rsp_ready_i;
  assign req_ready_o  = (state_q == lfr_pkg::StIdle);
  assign cmd_o.load   = req_ready_o && req_valid_i;
  assign cmd_o.commit = (state_q == lfr_pkg::StExec) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfr_pkg::StIdle: begin
        if (req_valid_i) begin
          state_d = lfr_pkg::StExec;
        end
      end
      lfr_pkg::StExec: begin
        if (slot_free) begin
          state_d = lfr_pkg::StIdle;
        end
      end
      default: state_d = lfr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/lfr_datapath.sv @@
// lfr_datapath: list heads, presence bits, link RAMs and result register.
// Depends on lfr_pkg and lfr_ram.
`timescale 1ns / 1ps

module lfr_datapath #(
  parameter int unsigned Depth = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfr_pkg::ctrl_cmd_t            cmd_i,
  output lfr_pkg::dp_status_t           status_o,
  input  logic [lfr_pkg::KindW-1:0]     kind_i,
  input  logic [lfr_pkg::FrameW-1:0]    frame_index_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic                          done_res_o,
  output logic [lfr_pkg::FrameW-1:0]    victim_frame_o,
  output logic [lfr_pkg::CountW-1:0]    evictable_count_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [IdxW-1:0]           oldest_q, oldest_d, newest_q, newest_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [Depth-1:0]          present_q, present_d;
  logic [lfr_pkg::KindW-1:0] kind_q;
  logic [IdxW-1:0]           frame_q, frame_d;
  logic                      valid_q;

  logic                      rsp_valid_q, rsp_valid_d;
  logic                      done_q;
  logic [lfr_pkg::FrameW-1:0] victim_q;
  logic [lfr_pkg::CountW-1:0] count_out_q;

  logic [IdxW-1:0] raddr, older_rd, newer_rd;
  logic            newer_we, older_we;
  logic [IdxW-1:0] newer_waddr, newer_wdata, older_waddr, older_wdata;

  logic is_evict, is_pin, is_unpin, nonempty, hit;
  logic do_detach, do_attach;

  // Evict works on the oldest frame; others on the requested one
  always_comb begin
    if (kind_i == lfr_pkg::KindEvict) begin
      frame_d = oldest_q;
    end else begin
      frame_d = frame_index_i[IdxW-1:0];
    end
  end

  assign raddr = cmd_i.load ? frame_d : frame_q;

  lfr_ram #(.Width(IdxW), .Depth(Depth)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (newer_we),
    .waddr_i (newer_waddr),
    .wdata_i (newer_wdata),
    .raddr_i (raddr),
    .rdata_o (newer_rd)
  );

  lfr_ram #(.Width(IdxW), .Depth(Depth)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (older_we),
    .waddr_i (older_waddr),
    .wdata_i (older_wdata),
    .raddr_i (raddr),
    .rdata_o (older_rd)
  );

  assign is_evict  = (kind_q == lfr_pkg::KindEvict);
  assign is_pin    = (kind_q == lfr_pkg::KindPin);
  assign is_unpin  = (kind_q == lfr_pkg::KindUnpin);
  assign nonempty  = (count_q != '0);
  assign hit       = present_q[frame_q];
  assign do_detach = (is_evict && nonempty) || (is_pin && valid_q && hit);
  assign do_attach = is_unpin && valid_q && !hit;

  always_comb begin
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    count_d     = count_q;
    present_d   = present_q;
    newer_we    = 1'b0;
    older_we    = 1'b0;
    newer_waddr = older_rd;
    newer_wdata = newer_rd;
    older_waddr = newer_rd;
    older_wdata = older_rd;
    if (do_detach) begin
      if (frame_q == oldest_q) begin
        oldest_d = newer_rd;
      end else begin
        newer_we = 1'b1;
      end
      if (frame_q == newest_q) begin
        newest_d = older_rd;
      end else begin
        older_we = 1'b1;
      end
      present_d[frame_q] = 1'b0;
      count_d            = count_q - CntW'(1);
      if (count_d == '0) begin
        oldest_d = '0;
        newest_d = '0;
      end
    end else if (do_attach) begin
      // newest frame's newer link is never followed, so it is not written
      older_we    = 1'b1;
      older_waddr = frame_q;
      older_wdata = nonempty ? newest_q : frame_q;
      newer_we    = nonempty;
      newer_waddr = newest_q;
      newer_wdata = frame_q;
      if (!nonempty) begin
        oldest_d = frame_q;
      end
      newest_d           = frame_q;
      present_d[frame_q] = 1'b1;
      count_d            = count_q + CntW'(1);
    end
    if (!cmd_i.commit) begin
      newer_we = 1'b0;
      older_we = 1'b0;
    end
  end

  assign rsp_valid_d = cmd_i.commit || (rsp_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      newest_q    <= '0;
      count_q     <= '0;
      present_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (cmd_i.commit) begin
        oldest_q  <= oldest_d;
        newest_q  <= newest_d;
        count_q   <= count_d;
        present_q <= present_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      frame_q <= frame_d;
      valid_q <= ({1'b0, frame_index_i} < lfr_pkg::CountW'(Depth));
    end
    if (cmd_i.commit) begin
      done_q      <= do_detach || do_attach;
      victim_q    <= (is_evict && do_detach) ? lfr_pkg::FrameW'(frame_q) : '0;
      count_out_q <= lfr_pkg::CountW'(count_d);
    end
  end

  assign status_o.rsp_pending = rsp_valid_q;
  assign rsp_valid_o          = rsp_valid_q;
  assign done_res_o           = done_q;
  assign victim_frame_o       = victim_q;
  assign evictable_count_o    = count_out_q;

endmodule

@@ hdl/lru_frame_replacer_unit.sv @@
// lru_frame_replacer_unit: top level of the LRU frame replacer.
// Depends on lfr_pkg, lfr_if, lfr_ctrl, lfr_datapath, lfr_ram.
`timescale 1ns / 1ps

// Keeps evictable buffer frames in least-recently-unpinned order as a doubly
// linked list held in two link RAMs. Each request (evict oldest, pin, unpin)
// yields one result with a done flag, the evicted frame and the number of
// evictable frames. A request first reads both link RAMs (registered read)
// at the affected frame; then, in the execute state once the result slot is
// free, it updates links, list heads and presence bits and loads the result
// register. A new request is taken in the cycle after the previous one
// finishes, never while one is in progress. A stalled result holds the
// following request in its execute state. Only frames below
// min(NUM_FRAMES, 64) are held; other indices are ignored.
module lru_frame_replacer_unit #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfr_req_if.sink       req_i,
  lfr_rsp_if.source     rsp_o
);

  localparam int unsigned Depth = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;

  lfr_pkg::ctrl_cmd_t  cmd;
  lfr_pkg::dp_status_t status;

  lfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  lfr_datapath #(.Depth(Depth)) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .kind_i            (req_i.kind),
    .frame_index_i     (req_i.frame_index),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .done_res_o        (rsp_o.done_res),
    .victim_frame_o    (rsp_o.victim_frame),
    .evictable_count_o (rsp_o.evictable_count)
  );

endmodule

@@ hdl/lfr_checker.sv @@
// lfr_checker: port-level assertions for lru_frame_replacer_unit, with bind.
// Depends on lfr_pkg and the top level's ports.
`timescale 1ns / 1ps

module lfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_done_i,
  input logic [lfr_pkg::FrameW-1:0]  rsp_victim_i,
  input logic [lfr_pkg::CountW-1:0]  rsp_count_i
);

  localparam logic [lfr_pkg::CountW-1:0] MaxCount = lfr_pkg::CountW'(64);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while one is in progress");

  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_done_i |-> rsp_victim_i == '0)
    else $error("victim frame set without a completed operation");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_count_i <= MaxCount)
    else $error("evictable count out of range");

endmodule

bind lru_frame_replacer_unit lfr_checker u_lfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_done_i   (rsp_o.done_res),
  .rsp_victim_i (rsp_o.victim_frame),
  .rsp_count_i  (rsp_o.evictable_count)
);
